@@ sv/spcr_pkg.sv @@
// Package with shared types and constants for the shape pair collision resolver.
package spcr_pkg;

    // Pair kinds carried in the func field.
    typedef enum logic [1:0] {
        t_box_box       = 2'd0,
        t_box_circle    = 2'd1,
        t_circle_box    = 2'd2,
        t_circle_circle = 2'd3
    } t_func;

    localparam int FUNC_WIDTH = 2;

endpackage

@@ sv/spcr_if.sv @@
// Valid/ready channel interface used for the input and result transfers.
interface spcr_if #(
    parameter int PAYLOAD_WIDTH = 32
) (
    input logic i_clk
);
    logic                     valid;
    logic                     ready;
    logic [PAYLOAD_WIDTH-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/spcr_isqrt.sv @@
// Pipelined integer square root, a fixed number of result bits per stage.
module spcr_isqrt #(
    parameter int RAD_WIDTH  = 66,
    parameter int ROOT_WIDTH = 33,
    parameter int SIDE_WIDTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [RAD_WIDTH-1:0]  i_rad,
    input  logic [SIDE_WIDTH-1:0] i_side,
    output logic                  o_valid,
    output logic [ROOT_WIDTH-1:0] o_root,
    output logic [SIDE_WIDTH-1:0] o_side
);
    localparam int BITS_PER_STAGE = 4;
    localparam int STAGES = (ROOT_WIDTH + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    // Root width rounded up to whole stages, and the remainder width.
    localparam int RT = STAGES * BITS_PER_STAGE;
    localparam int MW = RT + 2;

    logic [2*RT-1:0]       r_rad  [STAGES+1];
    logic [MW-1:0]         r_rem  [STAGES+1];
    logic [RT-1:0]         r_root [STAGES+1];
    logic [SIDE_WIDTH-1:0] r_side [STAGES+1];
    logic                  r_vld  [STAGES+1];

    always_comb begin
        r_rad[0]  = (2*RT)'(i_rad);
        r_rem[0]  = '0;
        r_root[0] = '0;
        r_side[0] = i_side;
        r_vld[0]  = i_valid;
    end

    // Each stage decides its group of root bits by shift and subtract,
    // taking two radicand bits per root bit.
    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [RT-1:0] n_root;
        logic [MW-1:0] n_rem;
        always_comb begin
            logic [MW+1:0] acc;
            logic [MW+1:0] trial;
            n_root = r_root[s];
            n_rem  = r_rem[s];
            for (int k = 0; k < BITS_PER_STAGE; k++) begin
                acc   = {n_rem, r_rad[s][2*(RT-1-s*BITS_PER_STAGE-k) +: 2]};
                trial = (MW+2)'({n_root, 2'b01});
                if (acc >= trial) begin
                    acc    = acc - trial;
                    n_root = {n_root[RT-2:0], 1'b1};
                end else begin
                    n_root = {n_root[RT-2:0], 1'b0};
                end
                n_rem = acc[MW-1:0];
            end
        end
        logic [2*RT-1:0]       r_rad_q;
        logic [MW-1:0]         r_rem_q;
        logic [RT-1:0]         r_root_q;
        logic [SIDE_WIDTH-1:0] r_side_q;
        logic                  r_vld_q;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld_q <= 1'b0;
            end else if (i_en) begin
                r_vld_q <= r_vld[s];
            end
            if (i_en) begin
                r_rad_q  <= r_rad[s];
                r_rem_q  <= n_rem;
                r_root_q <= n_root;
                r_side_q <= r_side[s];
            end
        end
        always_comb begin
            r_rad[s+1]  = r_rad_q;
            r_rem[s+1]  = r_rem_q;
            r_root[s+1] = r_root_q;
            r_side[s+1] = r_side_q;
            r_vld[s+1]  = r_vld_q;
        end
    end

    assign o_valid = r_vld[STAGES];
    assign o_root  = r_root[STAGES][ROOT_WIDTH-1:0];
    assign o_side  = r_side[STAGES];
endmodule

@@ sv/shape_pair_collision_resolver.sv @@
// Top level of the shape pair collision resolver.
// Pipeline: front-end stages 1 to 4, then ceil((COORD_WIDTH+3)/4) root stages, then
// AXIS_FRAC_BITS+4 divider stages and one output register.
// Throughput: one transfer per cycle; the whole pipeline stalls only when the
// output register holds a result that is not taken.
// Reset: synchronous active-low i_rst_n clears every valid bit; payload is not reset.
module shape_pair_collision_resolver #(
    parameter int COORD_WIDTH    = 32,
    parameter int AXIS_FRAC_BITS = 14
) (
    input logic i_clk,
    input logic i_rst_n,
    spcr_if.sink   i_in,
    spcr_if.source o_out
);
    localparam int CW  = COORD_WIDTH;
    localparam int AW  = AXIS_FRAC_BITS + 2;
    localparam int WW  = CW + 2;          // working coordinate width
    localparam int RW  = 2 * WW;          // squared distance width
    localparam int QW  = WW + 1;          // root width
    localparam int QB  = AXIS_FRAC_BITS + 1;
    localparam int DST = AXIS_FRAC_BITS + 3;

    // Pipeline advances unless the output register is full and blocked.
    logic w_en;
    logic r_out_vld;
    assign w_en    = !r_out_vld || o_out.ready;
    assign i_in.ready = w_en;

    // Unpack the input payload.
    logic [1:0]           w_func;
    logic signed [CW-1:0] w_f [4];
    logic signed [CW-1:0] w_s [4];
    always_comb begin
        w_func = i_in.payload[8*CW +: 2];
        for (int k = 0; k < 4; k++) begin
            w_f[k] = i_in.payload[(7-k)*CW +: CW];
            w_s[k] = i_in.payload[(3-k)*CW +: CW];
        end
    end

    // Stage 1: register inputs, swap for circle-box, form circle bounds.
    logic              r1_vld;
    logic [1:0]        r1_func;
    logic signed [WW-1:0] r1_a [4];
    logic signed [WW-1:0] r1_b [4];
    logic signed [WW-1:0] r1_cw, r1_ce, r1_cn, r1_cs;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_in.valid;
        end
        if (w_en) begin
            r1_func <= w_func;
            for (int k = 0; k < 4; k++) begin
                if (w_func == spcr_pkg::t_circle_box) begin
                    r1_a[k] <= WW'(w_s[k]);
                    r1_b[k] <= WW'(w_f[k]);
                end else begin
                    r1_a[k] <= WW'(w_f[k]);
                    r1_b[k] <= WW'(w_s[k]);
                end
            end
            if (w_func == spcr_pkg::t_circle_box) begin
                r1_cw <= WW'(w_f[0]) - WW'(w_f[2]);
                r1_ce <= WW'(w_f[0]) + WW'(w_f[2]);
                r1_cn <= WW'(w_f[1]) - WW'(w_f[2]);
                r1_cs <= WW'(w_f[1]) + WW'(w_f[2]);
            end else begin
                r1_cw <= WW'(w_s[0]) - WW'(w_s[2]);
                r1_ce <= WW'(w_s[0]) + WW'(w_s[2]);
                r1_cn <= WW'(w_s[1]) - WW'(w_s[2]);
                r1_cs <= WW'(w_s[1]) + WW'(w_s[2]);
            end
        end
    end

    // Stage 2: classify, select edge or point case, compute difference vector.
    // Side info kind: 0 miss, 1 fixed axis, 2 point axis.
    localparam logic [1:0] K_MISS = 2'd0, K_FIX = 2'd1, K_PT = 2'd2;
    logic                 n2_hit;
    logic [1:0]           n2_kind;
    logic signed [WW-1:0] n2_pen;
    logic signed [1:0]    n2_fx, n2_fy;
    logic signed [WW-1:0] n2_dx, n2_dy, n2_rad;
    always_comb begin
        logic signed [WW-1:0] pw, pe, pn, ps, kx, ky;
        logic [1:0] rx, ry;   // 0 inside, 1 low, 2 high
        n2_hit = 1'b0; n2_kind = K_MISS; n2_pen = '0; n2_fx = '0; n2_fy = '0;
        n2_dx = '0; n2_dy = '0; n2_rad = r1_b[2];
        pw = '0; pe = '0; pn = '0; ps = '0; kx = '0; ky = '0; rx = '0; ry = '0;
        case (r1_func)
            spcr_pkg::t_box_box: begin
                if (!(r1_a[1] <= r1_b[0] || r1_a[0] >= r1_b[1] ||
                      r1_a[3] <= r1_b[2] || r1_a[2] >= r1_b[3])) begin
                    pw = r1_b[1] - r1_a[0]; pe = r1_a[1] - r1_b[0];
                    pn = r1_b[3] - r1_a[2]; ps = r1_a[3] - r1_b[2];
                    n2_kind = K_FIX;
                    if (pw <= pe && pw <= pn && pw <= ps) begin
                        n2_pen = pw; n2_fx = -2'sd1;
                    end else if (pe <= pn && pe <= ps) begin
                        n2_pen = pe; n2_fx = 2'sd1;
                    end else if (pn <= ps) begin
                        n2_pen = pn; n2_fy = -2'sd1;
                    end else begin
                        n2_pen = ps; n2_fy = 2'sd1;
                    end
                end
            end
            spcr_pkg::t_circle_circle: begin
                n2_rad = r1_a[2] + r1_b[2];
                n2_dx = r1_b[0] - r1_a[0];
                n2_dy = r1_b[1] - r1_a[1];
                n2_kind = K_PT;
            end
            default: begin
                if (!(r1_a[2] >= r1_cs || r1_a[3] <= r1_cn ||
                      r1_a[0] >= r1_ce || r1_a[1] <= r1_cw)) begin
                    rx = (r1_b[0] < r1_a[0]) ? 2'd1 : ((r1_b[0] > r1_a[1]) ? 2'd2 : 2'd0);
                    ry = (r1_b[1] < r1_a[2]) ? 2'd1 : ((r1_b[1] > r1_a[3]) ? 2'd2 : 2'd0);
                    if (rx == 2'd0 && ry == 2'd0) begin
                        pn = r1_cs - r1_a[2]; ps = r1_a[3] - r1_cn;
                        pw = r1_ce - r1_a[0]; pe = r1_a[1] - r1_cw;
                        n2_kind = K_FIX;
                        if (pn <= ps && pn <= pw && pn <= pe) begin
                            n2_pen = pn; n2_fy = -2'sd1;
                        end else if (ps <= pe && ps <= pw) begin
                            n2_pen = ps; n2_fy = 2'sd1;
                        end else if (pe <= pw) begin
                            n2_pen = pe; n2_fx = 2'sd1;
                        end else begin
                            n2_pen = pw; n2_fx = -2'sd1;
                        end
                    end else if (rx == 2'd0 || ry == 2'd0) begin
                        n2_kind = K_FIX;
                        if (rx == 2'd1) begin
                            n2_pen = r1_ce - r1_a[0]; n2_fx = -2'sd1;
                        end else if (rx == 2'd2) begin
                            n2_pen = r1_a[1] - r1_cw; n2_fx = 2'sd1;
                        end else if (ry == 2'd1) begin
                            n2_pen = r1_cs - r1_a[2]; n2_fy = -2'sd1;
                        end else begin
                            n2_pen = r1_a[3] - r1_cn; n2_fy = 2'sd1;
                        end
                    end else begin
                        kx = (rx == 2'd1) ? r1_a[0] : r1_a[1];
                        ky = (ry == 2'd1) ? r1_a[2] : r1_a[3];
                        n2_dx = r1_b[0] - kx;
                        n2_dy = r1_b[1] - ky;
                        n2_kind = K_PT;
                    end
                end
            end
        endcase
        n2_hit = (n2_kind == K_FIX);
    end

    logic              r2_vld, r2_hit, r2_neg;
    logic [1:0]        r2_kind;
    logic signed [WW-1:0] r2_pen, r2_dx, r2_dy, r2_rad;
    logic signed [1:0] r2_fx, r2_fy;
    logic [WW-1:0]     r2_mx, r2_my;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
        if (w_en) begin
            r2_hit  <= n2_hit;
            r2_kind <= n2_kind;
            r2_neg  <= (r1_func == spcr_pkg::t_circle_box);
            r2_pen  <= n2_pen;
            r2_fx   <= n2_fx;
            r2_fy   <= n2_fy;
            r2_dx   <= n2_dx;
            r2_dy   <= n2_dy;
            r2_rad  <= n2_rad;
            r2_mx   <= n2_dx[WW-1] ? WW'(-n2_dx) : WW'(n2_dx);
            r2_my   <= n2_dy[WW-1] ? WW'(-n2_dy) : WW'(n2_dy);
        end
    end

    // Stage 3: square the magnitudes and the radius (one multiply each).
    logic              r3_vld, r3_hit, r3_neg;
    logic [1:0]        r3_kind;
    logic signed [WW-1:0] r3_pen, r3_dx, r3_dy, r3_rad;
    logic signed [1:0] r3_fx, r3_fy;
    logic [RW-1:0]     r3_sx, r3_sy, r3_sr;
    logic              r3_big;
    logic [WW-1:0]     w_mr;
    assign w_mr = r2_rad[WW-1] ? WW'(-r2_rad) : WW'(r2_rad);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r2_vld;
        end
        if (w_en) begin
            r3_hit  <= r2_hit;
            r3_kind <= r2_kind;
            r3_neg  <= r2_neg;
            r3_pen  <= r2_pen;
            r3_fx   <= r2_fx;
            r3_fy   <= r2_fy;
            r3_dx   <= r2_dx;
            r3_dy   <= r2_dy;
            r3_rad  <= r2_rad;
            r3_sx   <= RW'(r2_mx) * RW'(r2_mx);
            r3_sy   <= RW'(r2_my) * RW'(r2_my);
            r3_sr   <= RW'(w_mr) * RW'(w_mr);
            r3_big  <= ($signed({1'b0, r2_mx}) >= $signed({r2_rad[WW-1], r2_rad})) ||
                       ($signed({1'b0, r2_my}) >= $signed({r2_rad[WW-1], r2_rad}));
        end
    end

    // Stage 4: sum of squares and compare with the squared radius.
    logic              r4_vld, r4_hit, r4_neg, r4_pt;
    logic signed [WW-1:0] r4_pen, r4_dx, r4_dy, r4_rad;
    logic signed [1:0] r4_fx, r4_fy;
    logic [RW-1:0]     r4_d2;
    logic [RW:0]       w_d2;
    assign w_d2 = {1'b0, r3_sx} + {1'b0, r3_sy};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r4_vld <= r3_vld;
        end
        if (w_en) begin
            r4_hit <= r3_hit;
            r4_neg <= r3_neg;
            r4_pt  <= (r3_kind == K_PT) && (w_d2 < {1'b0, r3_sr}) && !r3_big;
            r4_pen <= r3_pen;
            r4_fx  <= r3_fx;
            r4_fy  <= r3_fy;
            r4_dx  <= r3_dx;
            r4_dy  <= r3_dy;
            r4_rad <= r3_rad;
            r4_d2  <= w_d2[RW-1:0];
        end
    end

    // Square root stage carries the rest of the item as side data.
    localparam int SW = 3 + 4*WW + 4;
    logic [SW-1:0] w_side_in, w_side_out;
    logic          w_sq_vld;
    logic [QW-1:0] w_root;
    assign w_side_in = {r4_hit, r4_neg, r4_pt, r4_pen, r4_dx, r4_dy, r4_rad, r4_fx, r4_fy};

    spcr_isqrt #(.RAD_WIDTH(RW), .ROOT_WIDTH(QW), .SIDE_WIDTH(SW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_vld),
        .i_rad   (r4_d2),
        .i_side  (w_side_in),
        .o_valid (w_sq_vld),
        .o_root  (w_root),
        .o_side  (w_side_out)
    );

    // Stage after root: final point penetration and divider setup.
    logic              s_hit, s_neg, s_pt;
    logic signed [WW-1:0] s_pen, s_dx, s_dy, s_rad;
    logic signed [1:0] s_fx, s_fy;
    assign {s_hit, s_neg, s_pt, s_pen, s_dx, s_dy, s_rad, s_fx, s_fy} = w_side_out;

    logic signed [WW:0] w_ppen;
    assign w_ppen = {s_rad[WW-1], s_rad} - $signed({1'b0, w_root[WW-1:0]});

    // Divider lanes: state per stage for x and y.
    logic              d_vld  [DST+1];
    logic              d_hit  [DST+1];
    logic              d_neg  [DST+1];
    logic              d_pt   [DST+1];
    logic              d_zero [DST+1];
    logic [WW:0]       d_pen  [DST+1];
    logic signed [1:0] d_fx   [DST+1];
    logic signed [1:0] d_fy   [DST+1];
    logic [QW-1:0]     d_den  [DST+1];
    logic [QW:0]       d_rx   [DST+1];
    logic [QW:0]       d_ry   [DST+1];
    logic [QB-1:0]     d_qx   [DST+1];
    logic [QB-1:0]     d_qy   [DST+1];
    logic              d_sx   [DST+1];
    logic              d_sy   [DST+1];
    logic              d_ox   [DST+1];
    logic              d_oy   [DST+1];

    // Divider entry register.
    logic r5_vld;
    logic r5_hit, r5_neg, r5_pt, r5_zero, r5_sx, r5_sy, r5_ox, r5_oy;
    logic [WW:0] r5_pen;
    logic signed [1:0] r5_fx, r5_fy;
    logic [QW-1:0] r5_den;
    logic [QW:0] r5_rx, r5_ry;
    always_ff @(posedge i_clk) begin
        logic [WW-1:0] ax, ay;
        ax = s_dx[WW-1] ? WW'(-s_dx) : WW'(s_dx);
        ay = s_dy[WW-1] ? WW'(-s_dy) : WW'(s_dy);
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (w_en) begin
            r5_vld <= w_sq_vld;
        end
        if (w_en) begin
            r5_hit  <= s_hit || (s_pt && w_ppen > 0);
            r5_neg  <= s_neg;
            r5_pt   <= s_pt;
            r5_zero <= (w_root == '0);
            r5_pen  <= s_pt ? (WW+1)'(w_ppen) : {s_pen[WW-1], s_pen};
            r5_fx   <= s_fx;
            r5_fy   <= s_fy;
            r5_den  <= w_root;
            r5_rx   <= (QW+1)'(ax);
            r5_ry   <= (QW+1)'(ay);
            r5_sx   <= s_dx[WW-1];
            r5_sy   <= s_dy[WW-1];
            r5_ox   <= {1'b0, ax} >= {1'b0, w_root};
            r5_oy   <= {1'b0, ay} >= {1'b0, w_root};
        end
    end

    always_comb begin
        d_vld[0] = r5_vld; d_hit[0] = r5_hit; d_neg[0] = r5_neg; d_pt[0] = r5_pt;
        d_zero[0] = r5_zero; d_pen[0] = r5_pen; d_fx[0] = r5_fx; d_fy[0] = r5_fy;
        d_den[0] = r5_den; d_rx[0] = r5_rx; d_ry[0] = r5_ry;
        d_qx[0] = '0; d_qy[0] = '0; d_sx[0] = r5_sx; d_sy[0] = r5_sy;
        d_ox[0] = r5_ox; d_oy[0] = r5_oy;
    end

    // Restoring division: the first QB stages each give one quotient bit for both components; the rest pass through.
    for (genvar s = 0; s < DST; s++) begin : g_div
        if (s < QB) begin : g_step
            logic [QW:0]   n_rx, n_ry, tx, ty;
            logic [QB-1:0] n_qx, n_qy;
            always_comb begin
                tx = d_rx[s] << 1;
                ty = d_ry[s] << 1;
                n_qx = d_qx[s] << 1;
                n_qy = d_qy[s] << 1;
                n_rx = tx;
                n_ry = ty;
                if (tx >= {1'b0, d_den[s]}) begin
                    n_rx = tx - {1'b0, d_den[s]};
                    n_qx[0] = 1'b1;
                end
                if (ty >= {1'b0, d_den[s]}) begin
                    n_ry = ty - {1'b0, d_den[s]};
                    n_qy[0] = 1'b1;
                end
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    d_vld[s+1] <= 1'b0;
                end else if (w_en) begin
                    d_vld[s+1] <= d_vld[s];
                end
                if (w_en) begin
                    d_rx[s+1] <= n_rx; d_ry[s+1] <= n_ry;
                    d_qx[s+1] <= n_qx; d_qy[s+1] <= n_qy;
                end
            end
        end else begin : g_pass
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    d_vld[s+1] <= 1'b0;
                end else if (w_en) begin
                    d_vld[s+1] <= d_vld[s];
                end
                if (w_en) begin
                    d_rx[s+1] <= d_rx[s]; d_ry[s+1] <= d_ry[s];
                    d_qx[s+1] <= d_qx[s]; d_qy[s+1] <= d_qy[s];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                d_hit[s+1] <= d_hit[s]; d_neg[s+1] <= d_neg[s]; d_pt[s+1] <= d_pt[s];
                d_zero[s+1] <= d_zero[s]; d_pen[s+1] <= d_pen[s];
                d_fx[s+1] <= d_fx[s]; d_fy[s+1] <= d_fy[s]; d_den[s+1] <= d_den[s];
                d_sx[s+1] <= d_sx[s]; d_sy[s+1] <= d_sy[s];
                d_ox[s+1] <= d_ox[s]; d_oy[s+1] <= d_oy[s];
            end
        end
    end

    // Final assembly: round, clamp, sign, degenerate axis, negate, saturate, clear on a miss.
    localparam logic [AW-1:0] ONE = AW'(1) << AXIS_FRAC_BITS;
    logic [AW-1:0]        w_ux, w_uy;
    logic signed [AW-1:0] w_ax, w_ay, w_fax, w_fay;
    logic [CW-1:0]        w_pen;
    always_comb begin
        logic [QB:0] rx, ry;
        rx = ({1'b0, d_qx[DST]} + (QB+1)'(1)) >> 1;
        ry = ({1'b0, d_qy[DST]} + (QB+1)'(1)) >> 1;
        w_ux = d_ox[DST] ? ONE : ((rx > (QB+1)'(ONE)) ? ONE : AW'(rx));
        w_uy = d_oy[DST] ? ONE : ((ry > (QB+1)'(ONE)) ? ONE : AW'(ry));
        w_ax = d_sx[DST] ? -$signed(w_ux) : $signed(w_ux);
        w_ay = d_sy[DST] ? -$signed(w_uy) : $signed(w_uy);
        if (d_pt[DST]) begin
            if (d_zero[DST] || (w_ux == '0 && w_uy == '0)) begin
                w_fax = '0;
                w_fay = $signed(ONE);
            end else begin
                w_fax = w_ax;
                w_fay = w_ay;
            end
        end else begin
            w_fax = AW'(d_fx[DST]) <<< AXIS_FRAC_BITS;
            w_fay = AW'(d_fy[DST]) <<< AXIS_FRAC_BITS;
        end
        if (d_neg[DST]) begin
            w_fax = -w_fax;
            w_fay = -w_fay;
        end
        if ($signed(d_pen[DST]) <= 0) begin
            w_pen = '0;
        end else if (d_pen[DST][WW-1:CW] != '0) begin
            w_pen = '1;
        end else begin
            w_pen = d_pen[DST][CW-1:0];
        end
        if (!d_hit[DST]) begin
            w_fax = '0; w_fay = '0; w_pen = '0;
        end
    end

    // Output register.
    logic          r_hit;
    logic [CW-1:0] r_pen;
    logic [AW-1:0] r_ax, r_ay;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= d_vld[DST];
        end
        if (w_en) begin
            r_hit <= d_hit[DST];
            r_pen <= w_pen;
            r_ax  <= w_fax;
            r_ay  <= w_fay;
        end
    end

    assign o_out.valid   = r_out_vld;
    assign o_out.payload = {r_hit, r_pen, r_ax, r_ay};

    // A miss never carries a nonzero result.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_hit |-> r_pen == '0 && r_ax == '0 && r_ay == '0)
        else $error("miss with nonzero result");
    // A hit always carries an axis on one of the unit directions or a point axis.
    a_hit_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_hit |-> r_ax != '0 || r_ay != '0)
        else $error("hit with zero axis");
    // A stalled result stays valid and keeps its penetration and x axis.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_out.ready |=> r_out_vld && $stable(r_pen) && $stable(r_ax))
        else $error("result changed under stall");
endmodule
